FILE: src/root_scan_handle_collector_unit_macros.svh
// Assertion macros used by the collector checker.
`ifndef ROOT_SCAN_HANDLE_COLLECTOR_UNIT_MACROS_SVH
`define ROOT_SCAN_HANDLE_COLLECTOR_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define RSHC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rshc: check failed");

// Next-cycle implication, off while reset is high.
`define RSHC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rshc: check failed");

// Next-cycle implication that also holds across reset.
`define RSHC_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rshc: check failed");

`endif

FILE: src/rshc_pkg.sv
// Types and codes shared by the root scan handle collector.
package rshc_pkg;

   typedef enum logic [2:0] {
      REQ_ALLOC   = 3'd0,
      REQ_PUSH    = 3'd1,
      REQ_POP     = 3'd2,
      REQ_COLLECT = 3'd3,
      REQ_REWRITE = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_OVERFLOW  = 3'd1,
      STATUS_UNDERFLOW = 3'd2,
      STATUS_EXHAUSTED = 3'd3,
      STATUS_BAD_INDEX = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MARK_ROOT,
      ST_MARK_SLOT,
      ST_MARK_SET,
      ST_SWEEP,
      ST_ALLOC_RD,
      ST_ALLOC_CHK,
      ST_DONE
   } state_type;

   typedef logic [9:0]  handle_id_type;
   typedef logic [10:0] root_index_type;
   typedef logic [11:0] pop_count_type;
   typedef logic [10:0] live_count_type;
   typedef logic [11:0] roots_in_use_type;

   typedef struct packed {
      logic          is_null;
      handle_id_type target;
   } root_entry_type;

   typedef struct packed {
      logic valid;
      logic mark;
   } slot_entry_type;

endpackage

FILE: src/root_scan_handle_collector_unit.sv
// Push, pop and rewrite: DONE registers the result; a request is accepted while it is shown.
// Allocate: ALLOC_RD and ALLOC_CHK per slot probed from the lowest-free pointer, usually one.
// Collect: MARK_ROOT and MARK_SLOT per root, plus MARK_SET if it names an in-range slot;
// then a sweep, bound by the single read port of the slot RAM; a full-pool allocate adds
// its collect. After reset a clear pass writes every slot entry, with req_ready low.
// Root stack depth, live count and the free pointer reset to zero.
module root_scan_handle_collector_unit #(
   parameter int HANDLE_SLOTS = 1024,
   parameter int ROOT_SLOTS   = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [2:0]                     req_type,
   input  rshc_pkg::handle_id_type        req_handle_id,
   input  logic                           req_handle_null,
   input  rshc_pkg::root_index_type       req_root_index,
   input  rshc_pkg::pop_count_type        req_pop_count,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rshc_pkg::status_type           rsp_status,
   output rshc_pkg::handle_id_type        rsp_alloc_id,
   output rshc_pkg::live_count_type       rsp_live_count,
   output rshc_pkg::roots_in_use_type     rsp_roots_in_use
);

   localparam int SW = $clog2(HANDLE_SLOTS);
   localparam int CW = $clog2(HANDLE_SLOTS + 1);
   localparam int RW = $clog2(ROOT_SLOTS);
   localparam int DW = $clog2(ROOT_SLOTS + 1);
   localparam int SLOT_BITS = $bits(rshc_pkg::slot_entry_type);
   localparam int ROOT_BITS = $bits(rshc_pkg::root_entry_type);
   localparam logic [CW-1:0] SLOT_COUNT = CW'(HANDLE_SLOTS);
   localparam logic [CW-1:0] LAST_SLOT  = CW'(HANDLE_SLOTS - 1);
   localparam logic [DW-1:0] ROOT_COUNT = DW'(ROOT_SLOTS);
   localparam logic [31:0]   SLOT_LIMIT = 32'(HANDLE_SLOTS);

   rshc_pkg::state_type state_ff, state_in;

   logic [DW-1:0] depth_ff, depth_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] hint_ff, hint_in;
   logic          hint_found_ff, hint_found_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          sweep_rd_ff, sweep_rd_in;
   logic [SW-1:0] sweep_addr_ff, sweep_addr_in;
   logic [DW-1:0] root_cnt_ff, root_cnt_in;
   rshc_pkg::handle_id_type target_ff, target_in;
   logic          alloc_pend_ff, alloc_pend_in;
   rshc_pkg::status_type status_ff, status_in;
   logic [SW-1:0] alloc_ff, alloc_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   rshc_pkg::status_type          rsp_status_ff, rsp_status_in;
   rshc_pkg::handle_id_type       rsp_alloc_id_ff, rsp_alloc_id_in;
   rshc_pkg::live_count_type      rsp_live_count_ff, rsp_live_count_in;
   rshc_pkg::roots_in_use_type    rsp_roots_in_use_ff, rsp_roots_in_use_in;

   logic                     slot_wr_en;
   logic [SW-1:0]            slot_wr_addr;
   rshc_pkg::slot_entry_type slot_wr;
   logic [SW-1:0]            slot_rd_addr;
   logic [SLOT_BITS-1:0]     slot_rd_bits;
   rshc_pkg::slot_entry_type slot_rd;

   logic                     root_wr_en;
   logic [RW-1:0]            root_wr_addr;
   rshc_pkg::root_entry_type root_wr;
   logic [ROOT_BITS-1:0]     root_rd_bits;
   rshc_pkg::root_entry_type root_rd;

   logic accept, pool_full, stack_full, pop_bad, idx_bad, target_ok;
   logic hint_open, sweep_issue, sweep_end, clear_last, rsp_free, roots_left;

   rshc_ram #(.DEPTH(HANDLE_SLOTS), .WIDTH(SLOT_BITS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_bits)
   );

   rshc_ram #(.DEPTH(ROOT_SLOTS), .WIDTH(ROOT_BITS)) u_root_ram (
      .clock   (clock),
      .wr_en   (root_wr_en),
      .wr_addr (root_wr_addr),
      .wr_data (root_wr),
      .rd_addr (root_cnt_ff[RW-1:0]),
      .rd_data (root_rd_bits)
   );

   assign slot_rd = rshc_pkg::slot_entry_type'(slot_rd_bits);
   assign root_rd = rshc_pkg::root_entry_type'(root_rd_bits);

   assign req_ready   = (state_ff == rshc_pkg::ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign pool_full   = (total_ff >= SLOT_COUNT);
   assign stack_full  = (depth_ff >= ROOT_COUNT);
   assign pop_bad     = (32'(req_pop_count) > 32'(depth_ff));
   assign idx_bad     = (32'(req_root_index) >= 32'(depth_ff));
   assign target_ok   = !root_rd.is_null && (32'(root_rd.target) < SLOT_LIMIT);
   assign hint_open   = (hint_ff < SLOT_COUNT);
   assign sweep_issue = (cnt_ff < SLOT_COUNT);
   assign sweep_end   = !sweep_issue && !sweep_rd_ff;
   assign clear_last  = (cnt_ff == LAST_SLOT);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign roots_left  = (root_cnt_ff < depth_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rshc_pkg::ST_CLEAR: begin
            if (clear_last) state_in = rshc_pkg::ST_IDLE;
         end
         rshc_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  rshc_pkg::REQ_ALLOC: begin
                     state_in = pool_full ? rshc_pkg::ST_MARK_ROOT : rshc_pkg::ST_ALLOC_RD;
                  end
                  rshc_pkg::REQ_COLLECT: state_in = rshc_pkg::ST_MARK_ROOT;
                  default:               state_in = rshc_pkg::ST_DONE;
               endcase
            end
         end
         rshc_pkg::ST_MARK_ROOT: begin
            state_in = roots_left ? rshc_pkg::ST_MARK_SLOT : rshc_pkg::ST_SWEEP;
         end
         rshc_pkg::ST_MARK_SLOT: begin
            state_in = target_ok ? rshc_pkg::ST_MARK_SET : rshc_pkg::ST_MARK_ROOT;
         end
         rshc_pkg::ST_MARK_SET: state_in = rshc_pkg::ST_MARK_ROOT;
         rshc_pkg::ST_SWEEP: begin
            if (sweep_end) begin
               if (alloc_pend_ff && !pool_full) state_in = rshc_pkg::ST_ALLOC_RD;
               else                             state_in = rshc_pkg::ST_DONE;
            end
         end
         rshc_pkg::ST_ALLOC_RD: begin
            state_in = hint_open ? rshc_pkg::ST_ALLOC_CHK : rshc_pkg::ST_DONE;
         end
         rshc_pkg::ST_ALLOC_CHK: begin
            state_in = slot_rd.valid ? rshc_pkg::ST_ALLOC_RD : rshc_pkg::ST_DONE;
         end
         rshc_pkg::ST_DONE: begin
            if (rsp_free) state_in = rshc_pkg::ST_IDLE;
         end
         default: state_in = rshc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      depth_in            = depth_ff;
      total_in            = total_ff;
      hint_in             = hint_ff;
      hint_found_in       = hint_found_ff;
      cnt_in              = cnt_ff;
      sweep_rd_in         = 1'b0;
      sweep_addr_in       = cnt_ff[SW-1:0];
      root_cnt_in         = root_cnt_ff;
      target_in           = target_ff;
      alloc_pend_in       = alloc_pend_ff;
      status_in           = status_ff;
      alloc_in            = alloc_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_status_in       = rsp_status_ff;
      rsp_alloc_id_in     = rsp_alloc_id_ff;
      rsp_live_count_in   = rsp_live_count_ff;
      rsp_roots_in_use_in = rsp_roots_in_use_ff;
      slot_wr_en          = 1'b0;
      slot_wr_addr        = cnt_ff[SW-1:0];
      slot_wr             = '0;
      slot_rd_addr        = cnt_ff[SW-1:0];
      root_wr_en          = 1'b0;
      root_wr_addr        = depth_ff[RW-1:0];
      root_wr.is_null     = req_handle_null;
      root_wr.target      = req_handle_id;

      case (state_ff)
         rshc_pkg::ST_CLEAR: begin
            slot_wr_en = 1'b1;
            cnt_in     = clear_last ? '0 : cnt_ff + CW'(1);
         end
         rshc_pkg::ST_IDLE: begin
            if (accept) begin
               status_in     = rshc_pkg::STATUS_OK;
               alloc_in      = '0;
               alloc_pend_in = 1'b0;
               root_cnt_in   = '0;
               cnt_in        = '0;
               hint_found_in = 1'b0;
               case (req_type)
                  rshc_pkg::REQ_ALLOC: alloc_pend_in = 1'b1;
                  rshc_pkg::REQ_PUSH: begin
                     if (stack_full) begin
                        status_in = rshc_pkg::STATUS_OVERFLOW;
                     end else begin
                        root_wr_en = 1'b1;
                        depth_in   = depth_ff + DW'(1);
                     end
                  end
                  rshc_pkg::REQ_POP: begin
                     if (pop_bad) status_in = rshc_pkg::STATUS_UNDERFLOW;
                     else         depth_in  = depth_ff - DW'(req_pop_count);
                  end
                  rshc_pkg::REQ_REWRITE: begin
                     root_wr_addr = RW'(req_root_index);
                     if (idx_bad) status_in  = rshc_pkg::STATUS_BAD_INDEX;
                     else         root_wr_en = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         rshc_pkg::ST_MARK_SLOT: begin
            slot_rd_addr = SW'(root_rd.target);
            target_in    = root_rd.target;
            if (!target_ok) root_cnt_in = root_cnt_ff + DW'(1);
         end
         rshc_pkg::ST_MARK_SET: begin
            slot_wr_addr = SW'(target_ff);
            slot_wr      = '{valid: 1'b1, mark: 1'b1};
            slot_wr_en   = slot_rd.valid;
            root_cnt_in  = root_cnt_ff + DW'(1);
         end
         rshc_pkg::ST_SWEEP: begin
            sweep_rd_in = sweep_issue;
            if (sweep_issue) cnt_in = cnt_ff + CW'(1);
            if (sweep_rd_ff) begin
               slot_wr_en   = 1'b1;
               slot_wr_addr = sweep_addr_ff;
               slot_wr      = '{valid: slot_rd.valid && slot_rd.mark, mark: 1'b0};
               if (slot_rd.valid && !slot_rd.mark && total_ff != '0) begin
                  total_in = total_ff - CW'(1);
               end
               if (!(slot_rd.valid && slot_rd.mark) && !hint_found_ff) begin
                  hint_in       = CW'(sweep_addr_ff);
                  hint_found_in = 1'b1;
               end
            end
            if (sweep_end) begin
               if (!hint_found_ff) hint_in = SLOT_COUNT;
               if (alloc_pend_ff && pool_full) status_in = rshc_pkg::STATUS_EXHAUSTED;
            end
         end
         rshc_pkg::ST_ALLOC_RD: begin
            slot_rd_addr = hint_ff[SW-1:0];
            if (!hint_open) status_in = rshc_pkg::STATUS_EXHAUSTED;
         end
         rshc_pkg::ST_ALLOC_CHK: begin
            hint_in = hint_ff + CW'(1);
            if (!slot_rd.valid) begin
               slot_wr_en   = 1'b1;
               slot_wr_addr = hint_ff[SW-1:0];
               slot_wr      = '{valid: 1'b1, mark: 1'b0};
               total_in     = total_ff + CW'(1);
               alloc_in     = hint_ff[SW-1:0];
            end
         end
         rshc_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_status_in       = status_ff;
               rsp_alloc_id_in     = rshc_pkg::handle_id_type'(alloc_ff);
               rsp_live_count_in   = rshc_pkg::live_count_type'(total_ff);
               rsp_roots_in_use_in = rshc_pkg::roots_in_use_type'(depth_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rshc_pkg::ST_CLEAR;
         depth_ff      <= '0;
         total_ff      <= '0;
         hint_ff       <= '0;
         hint_found_ff <= 1'b0;
         cnt_ff        <= '0;
         sweep_rd_ff   <= 1'b0;
         root_cnt_ff   <= '0;
         alloc_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         total_ff      <= total_in;
         hint_ff       <= hint_in;
         hint_found_ff <= hint_found_in;
         cnt_ff        <= cnt_in;
         sweep_rd_ff   <= sweep_rd_in;
         root_cnt_ff   <= root_cnt_in;
         alloc_pend_ff <= alloc_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_addr_ff       <= sweep_addr_in;
      target_ff           <= target_in;
      status_ff           <= status_in;
      alloc_ff            <= alloc_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_alloc_id_ff     <= rsp_alloc_id_in;
      rsp_live_count_ff   <= rsp_live_count_in;
      rsp_roots_in_use_ff <= rsp_roots_in_use_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_alloc_id     = rsp_alloc_id_ff;
   assign rsp_live_count   = rsp_live_count_ff;
   assign rsp_roots_in_use = rsp_roots_in_use_ff;

endmodule

FILE: src/rshc_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module rshc_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/rshc_checker.sv
// Port-level checks for the collector, bound to the top level.
`include "root_scan_handle_collector_unit_macros.svh"

module rshc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input rshc_pkg::status_type        rsp_status,
   input rshc_pkg::handle_id_type     rsp_alloc_id,
   input rshc_pkg::live_count_type    rsp_live_count,
   input rshc_pkg::roots_in_use_type  rsp_roots_in_use
);

   `RSHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `RSHC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready,
      $stable(rsp_status) && $stable(rsp_alloc_id) && $stable(rsp_live_count) &&
      $stable(rsp_roots_in_use))
   `RSHC_ASSERT_NOW(a_fail_no_id, rsp_valid && rsp_status != rshc_pkg::STATUS_OK, rsp_alloc_id == '0)
   `RSHC_ASSERT_ALWAYS(a_reset_quiet, reset, !rsp_valid && !req_ready)

endmodule

bind root_scan_handle_collector_unit rshc_checker u_rshc_checker (.*);
